@@ sv/assert_macros.svh @@
// Assertion shorthands for the checker file.
// No dependencies; pulled in with an include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/lesf_pkg.sv @@
// Shared constants, register indexes and stage control types for the square finder.
// No dependencies; imported by every module of the block except lesf_ram.
`timescale 1ns / 1ps

package lesf_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int ROW_BITS_DEF  = 16;

   localparam int CHAR_W     = 8;
   localparam int SIDE_W     = 11;
   localparam int OUT_COL_W  = 10;
   localparam int OUT_ROW_W  = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST    = 8'd46;
   localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = 8'd111;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ROW_WIDTH     = 2'd0,
      CSR_EMPTY_CHAR    = 2'd1,
      CSR_OBSTACLE_CHAR = 2'd2
   } csr_index_type;

   // control bits of a cell held in the scoring stage
   typedef struct packed {
      logic last;       // final cell of the map
      logic first_row;
      logic first_col;
      logic fwd;        // line-buffer entry was being written as it was read
   } cell_ctl_type;

endpackage

@@ sv/largest_empty_square_finder_unit.sv @@
// Top level of the largest empty square finder.
// Depends on lesf_pkg, lesf_ram, lesf_front and lesf_score.
//
// Usage:
//  - req_* carries map cells in raster order, one character per word;
//    req_tlast marks the final cell of a map.
//  - rsp_* carries one word per map: side and bottom-right corner of the
//    largest empty square (row and column read 0 when the side is 0).
//  - csr_* writes row width, empty character and obstacle character
//    (indexes 0, 1, 2) while the block is idle; writes take effect at once.
// Throughput: one cell per clock while req_tready is high. Each cell does one
//  line-buffer read and, once in the scoring stage, one write-back on a simple
//  dual-port RAM; a same-entry read/write overlap is forwarded around the RAM.
// Result: the last cell passes the scoring-stage register and then the result
//  register, which drives rsp_tvalid (the RAM read shares the accepting edge).
// Stalls: the result register frees the input while a word waits; only a
//  second map end reaching the scoring stage before the first word is
//  taken holds req_tready low.
// Reset: counters, best square and registers return to their defaults
//  (width 1, '.', 'o'); the line buffer is not cleared and needs no pass.
`timescale 1ns / 1ps

module largest_empty_square_finder_unit #(
   parameter int MAX_WIDTH = lesf_pkg::MAX_WIDTH_DEF,
   parameter int ROW_BITS  = lesf_pkg::ROW_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lesf_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] cell_char
   input  logic                             req_tlast,   // last_cell
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [10:0] square_side, [20:11] square_right_col, [36:21] square_bottom_row, [39:37] zero
   output logic [lesf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [lesf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lesf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import lesf_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic [COL_BITS-1:0] last_col_ff, last_col_in;
   logic [CHAR_W-1:0]   empty_ff, obstacle_ff;

   logic                take, stall, proc;
   logic [COL_BITS-1:0] rd_addr;
   logic                s1_valid;
   cell_ctl_type        s1_ctl;
   logic [CHAR_W-1:0]   s1_char;
   logic [COL_BITS-1:0] s1_col;
   logic [ROW_BITS-1:0] s1_row;
   logic [SIDE_W-1:0]   s1_fwd_data;
   logic [SIDE_W-1:0]   ram_data;
   logic                wb_en;
   logic [COL_BITS-1:0] wb_addr;
   logic [SIDE_W-1:0]   wb_data;
   logic [SIDE_W-1:0]   rsp_side;
   logic [OUT_COL_W-1:0] rsp_col;
   logic [OUT_ROW_W-1:0] rsp_row;

   // width is kept as the index of the last column, clamped to 1..MAX_WIDTH
   always_comb begin
      if (csr_wdata == '0) begin
         last_col_in = '0;
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         last_col_in = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         last_col_in = COL_BITS'(csr_wdata - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= '0;
         empty_ff    <= EMPTY_CHAR_RST;
         obstacle_ff <= OBSTACLE_CHAR_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ROW_WIDTH:     last_col_ff <= last_col_in;
            CSR_EMPTY_CHAR:    empty_ff    <= csr_wdata[CHAR_W-1:0];
            CSR_OBSTACLE_CHAR: obstacle_ff <= csr_wdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   // hold a map end in the scoring stage while the previous result waits
   assign stall      = s1_valid && s1_ctl.last && rsp_tvalid;
   assign req_tready = !stall;
   assign take       = req_tvalid && req_tready;
   assign proc       = s1_valid && !stall;

   lesf_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ROW_BITS  (ROW_BITS),
      .COL_BITS  (COL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .hold        (stall),
      .cell_char   (req_tdata[CHAR_W-1:0]),
      .last_cell   (req_tlast),
      .last_col    (last_col_ff),
      .wb_en       (wb_en),
      .wb_addr     (wb_addr),
      .wb_data     (wb_data),
      .rd_addr     (rd_addr),
      .s1_valid    (s1_valid),
      .s1_ctl      (s1_ctl),
      .s1_char     (s1_char),
      .s1_col      (s1_col),
      .s1_row      (s1_row),
      .s1_fwd_data (s1_fwd_data)
   );

   lesf_ram #(
      .WIDTH (SIDE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_addr),
      .wr_data (wb_data),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   lesf_score #(
      .COL_BITS (COL_BITS),
      .ROW_BITS (ROW_BITS)
   ) u_score (
      .clock         (clock),
      .reset         (reset),
      .proc          (proc),
      .ctl           (s1_ctl),
      .cell_char     (s1_char),
      .col           (s1_col),
      .row           (s1_row),
      .fwd_data      (s1_fwd_data),
      .ram_data      (ram_data),
      .empty_char    (empty_ff),
      .obstacle_char (obstacle_ff),
      .rsp_tready    (rsp_tready),
      .wb_en         (wb_en),
      .wb_addr       (wb_addr),
      .wb_data       (wb_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_side      (rsp_side),
      .rsp_col       (rsp_col),
      .rsp_row       (rsp_row)
   );

   assign rsp_tdata = {3'b000, rsp_row, rsp_col, rsp_side};

endmodule

@@ sv/lesf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module lesf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lesf_front.sv @@
// Input stage: column/row tracking, line-buffer read address and the scoring-stage register.
// Depends on lesf_pkg.
`timescale 1ns / 1ps

module lesf_front #(
   parameter int MAX_WIDTH = lesf_pkg::MAX_WIDTH_DEF,
   parameter int ROW_BITS  = lesf_pkg::ROW_BITS_DEF,
   parameter int COL_BITS  = $clog2(MAX_WIDTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic                           hold,
   input  logic [lesf_pkg::CHAR_W-1:0]    cell_char,
   input  logic                           last_cell,
   input  logic [COL_BITS-1:0]            last_col,
   input  logic                           wb_en,
   input  logic [COL_BITS-1:0]            wb_addr,
   input  logic [lesf_pkg::SIDE_W-1:0]    wb_data,
   output logic [COL_BITS-1:0]            rd_addr,
   output logic                           s1_valid,
   output lesf_pkg::cell_ctl_type         s1_ctl,
   output logic [lesf_pkg::CHAR_W-1:0]    s1_char,
   output logic [COL_BITS-1:0]            s1_col,
   output logic [ROW_BITS-1:0]            s1_row,
   output logic [lesf_pkg::SIDE_W-1:0]    s1_fwd_data
);

   import lesf_pkg::*;

   localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

   logic [COL_BITS-1:0] col_count_ff, col_count_in;
   logic [ROW_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_BITS-1:0] col_cur;
   logic [ROW_BITS-1:0] row_cur;
   logic                wrap_early;
   logic                row_end;

   logic                s1_valid_ff;
   cell_ctl_type        s1_ctl_ff;
   logic [CHAR_W-1:0]   s1_char_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic [ROW_BITS-1:0] s1_row_ff;
   logic [SIDE_W-1:0]   s1_fwd_data_ff;

   // a narrowed row width ends the current row before this cell
   always_comb begin
      wrap_early = col_count_ff > last_col;
      col_cur    = wrap_early ? '0 : col_count_ff;
      row_cur    = row_count_ff;
      if (wrap_early && row_count_ff != ROW_MAX) begin
         row_cur = row_count_ff + 1'b1;
      end
      row_end = col_cur == last_col;

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (take) begin
         if (last_cell) begin
            col_count_in = '0;
            row_count_in = '0;
         end else if (row_end) begin
            col_count_in = '0;
            row_count_in = (row_cur != ROW_MAX) ? row_cur + 1'b1 : row_cur;
         end else begin
            col_count_in = col_cur + 1'b1;
            row_count_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (!hold) begin
            s1_valid_ff <= take;
         end
      end
   end

   // same-address write in this cycle: the RAM returns old data, so keep the new word
   always_ff @(posedge clock) begin
      if (take) begin
         s1_ctl_ff.last      <= last_cell;
         s1_ctl_ff.first_row <= row_cur == '0;
         s1_ctl_ff.first_col <= col_cur == '0;
         s1_ctl_ff.fwd       <= wb_en && (wb_addr == col_cur);
         s1_char_ff          <= cell_char;
         s1_col_ff           <= col_cur;
         s1_row_ff           <= row_cur;
         s1_fwd_data_ff      <= wb_data;
      end
   end

   assign rd_addr     = col_cur;
   assign s1_valid    = s1_valid_ff;
   assign s1_ctl      = s1_ctl_ff;
   assign s1_char     = s1_char_ff;
   assign s1_col      = s1_col_ff;
   assign s1_row      = s1_row_ff;
   assign s1_fwd_data = s1_fwd_data_ff;

endmodule

@@ sv/lesf_score.sv @@
// Scoring stage: three-way minimum, best-square tracking, line-buffer write-back, result register.
// Depends on lesf_pkg.
`timescale 1ns / 1ps

module lesf_score #(
   parameter int COL_BITS = 10,
   parameter int ROW_BITS = lesf_pkg::ROW_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           proc,
   input  lesf_pkg::cell_ctl_type         ctl,
   input  logic [lesf_pkg::CHAR_W-1:0]    cell_char,
   input  logic [COL_BITS-1:0]            col,
   input  logic [ROW_BITS-1:0]            row,
   input  logic [lesf_pkg::SIDE_W-1:0]    fwd_data,
   input  logic [lesf_pkg::SIDE_W-1:0]    ram_data,
   input  logic [lesf_pkg::CHAR_W-1:0]    empty_char,
   input  logic [lesf_pkg::CHAR_W-1:0]    obstacle_char,
   input  logic                           rsp_tready,
   output logic                           wb_en,
   output logic [COL_BITS-1:0]            wb_addr,
   output logic [lesf_pkg::SIDE_W-1:0]    wb_data,
   output logic                           rsp_tvalid,
   output logic [lesf_pkg::SIDE_W-1:0]    rsp_side,
   output logic [lesf_pkg::OUT_COL_W-1:0] rsp_col,
   output logic [lesf_pkg::OUT_ROW_W-1:0] rsp_row
);

   import lesf_pkg::*;

   logic [SIDE_W-1:0]    up, min_ul, min_all, score;
   logic [SIDE_W:0]      grown;
   logic [SIDE_W-1:0]    left_ff, diag_ff;
   logic [SIDE_W-1:0]    best_side_ff, nb_side;
   logic [COL_BITS-1:0]  best_col_ff, nb_col;
   logic [ROW_BITS-1:0]  best_row_ff, nb_row;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SIDE_W-1:0]    rsp_side_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;

   always_comb begin
      up      = ctl.fwd ? fwd_data : ram_data;
      min_ul  = (up < left_ff) ? up : left_ff;
      min_all = (min_ul < diag_ff) ? min_ul : diag_ff;
      grown   = {1'b0, min_all} + 1'b1;

      if (cell_char == obstacle_char) begin
         score = '0;
      end else if (ctl.first_row || ctl.first_col) begin
         score = {{(SIDE_W-1){1'b0}}, cell_char == empty_char};
      end else if (grown[SIDE_W]) begin
         score = '1;
      end else begin
         score = grown[SIDE_W-1:0];
      end

      // strict compare keeps the topmost, then leftmost square on ties
      if (score > best_side_ff) begin
         nb_side = score;
         nb_col  = col;
         nb_row  = row;
      end else begin
         nb_side = best_side_ff;
         nb_col  = best_col_ff;
         nb_row  = best_row_ff;
      end

      rsp_valid_in = (proc && ctl.last) || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         diag_ff      <= '0;
         best_side_ff <= '0;
         best_col_ff  <= '0;
         best_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            left_ff <= score;
            diag_ff <= up;
            if (ctl.last) begin
               best_side_ff <= '0;
               best_col_ff  <= '0;
               best_row_ff  <= '0;
            end else begin
               best_side_ff <= nb_side;
               best_col_ff  <= nb_col;
               best_row_ff  <= nb_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc && ctl.last) begin
         rsp_side_ff <= nb_side;
         rsp_col_ff  <= (nb_side != '0) ? OUT_COL_W'(nb_col) : '0;
         rsp_row_ff  <= (nb_side != '0) ? OUT_ROW_W'(nb_row) : '0;
      end
   end

   assign wb_en      = proc;
   assign wb_addr    = col;
   assign wb_data    = score;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_side   = rsp_side_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_row    = rsp_row_ff;

endmodule

@@ sv/lesf_checker.sv @@
// Port-level checks for the square finder, bound to the top level.
// Depends on lesf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lesf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lesf_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import lesf_pkg::*;

   // a waiting word stays put until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no square means no corner
   `ASSERT_IMPL(a_zero_corner, clock, reset, rsp_tvalid && rsp_tdata[10:0] == 11'd0, rsp_tdata[36:11] == 26'd0)

   // input backpressure only happens behind an undelivered result
   `ASSERT_IMPL(a_stall_cause, clock, reset, !req_tready, rsp_tvalid)

   // a new result follows a map end, or a map end held behind the previous word
   `ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(!req_tready || (req_tvalid && req_tready && req_tlast), 2))

endmodule

bind largest_empty_square_finder_unit lesf_checker u_lesf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/largest_empty_square_finder_unit_tb.sv @@
// Self-checking bench for the largest empty square finder: streams random and directed
// maps, predicts each map's best square in-bench and compares every rsp word.
// Depends on lesf_pkg and largest_empty_square_finder_unit.
`timescale 1ns / 1ps

module largest_empty_square_finder_unit_tb;
   import lesf_pkg::*;

   localparam int MAX_COLS = MAX_WIDTH_DEF;
   localparam int ROW_MAX  = (1 << ROW_BITS_DEF) - 1;
   localparam logic [CHAR_W-1:0] DOT  = EMPTY_CHAR_RST;
   localparam logic [CHAR_W-1:0] ROCK = OBSTACLE_CHAR_RST;

   typedef struct packed {
      logic              last;
      logic [CHAR_W-1:0] ch;
   } map_cell_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] bottom_row;
      logic [OUT_COL_W-1:0] right_col;
      logic [SIDE_W-1:0]    side;
   } square_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] cell_char
   logic                  req_tlast = 1'b0; // last_cell
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [10:0] square_side, [20:11] square_right_col, [36:21] square_bottom_row
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   largest_empty_square_finder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   map_cell_type pending_cells[$];
   square_type   expected_squares[$];
   int        cells_queued = 0;
   int        cells_taken = 0;
   int        err_count = 0;
   bit        req_took = 1'b0;
   bit        rsp_took = 1'b0;

   // predictor state
   logic [SIDE_W-1:0]    line_sizes [MAX_COLS];
   logic [SIDE_W-1:0]    left_sz, diag_sz, best_side;
   int                   col_idx, row_idx, best_col, best_row;
   logic [CSR_DATA_W-1:0] cfg_width;
   logic [CHAR_W-1:0]    cfg_empty, cfg_obstacle;

   // stimulus-side copy of the map format
   logic [CHAR_W-1:0] cur_empty = DOT, cur_obst = ROCK;

   function automatic void flag_error(string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endfunction

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic void clear_map();
      left_sz = '0;
      diag_sz = '0;
      col_idx = 0;
      row_idx = 0;
      best_side = '0;
      best_col = 0;
      best_row = 0;
   endfunction

   function automatic void next_row();
      col_idx = 0;
      left_sz = '0;
      diag_sz = '0;
      if (row_idx < ROW_MAX) row_idx++;
   endfunction

   function automatic void score_cell(map_cell_type mcell);
      int w, col;
      logic [SIDE_W-1:0] up, sc, m;
      square_type sq;
      w = (cfg_width == 0) ? 1 : int'(cfg_width);
      if (w > MAX_COLS) w = MAX_COLS;
      if (col_idx >= w) next_row();
      col = col_idx;
      up = line_sizes[col];
      if (mcell.ch == cfg_obstacle)
         sc = '0;
      else if (row_idx == 0 || col == 0)
         sc = {{(SIDE_W-1){1'b0}}, mcell.ch == cfg_empty};
      else begin
         m = (up < left_sz) ? up : left_sz;
         if (diag_sz < m) m = diag_sz;
         sc = m + 1'b1;
      end
      // strict compare keeps the topmost, then leftmost square on ties
      if (sc > best_side) begin
         best_side = sc;
         best_col = col;
         best_row = row_idx;
      end
      line_sizes[col] = sc;
      diag_sz = up;
      left_sz = sc;
      if (col + 1 >= w) next_row();
      else col_idx = col + 1;
      if (mcell.last) begin
         sq.side = best_side;
         sq.right_col = (best_side != 0) ? best_col[OUT_COL_W-1:0] : '0;
         sq.bottom_row = (best_side != 0) ? best_row[OUT_ROW_W-1:0] : '0;
         expected_squares.push_back(sq);
         clear_map();
      end
   endfunction

   // monitor: register writes, accepted cells and result words, all at the rising edge
   always @(posedge clock) begin
      square_type want, got;
      req_took <= !reset && req_tvalid && req_tready;
      rsp_took <= !reset && rsp_tvalid && rsp_tready;
      if (reset) begin
         cfg_width = CSR_DATA_W'(1);
         cfg_empty = DOT;
         cfg_obstacle = ROCK;
         for (int i = 0; i < MAX_COLS; i++) line_sizes[i] = '0;
         clear_map();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_ROW_WIDTH:     cfg_width = csr_wdata;
               CSR_EMPTY_CHAR:    cfg_empty = csr_wdata[CHAR_W-1:0];
               CSR_OBSTACLE_CHAR: cfg_obstacle = csr_wdata[CHAR_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            cells_taken++;
            score_cell({req_tlast, req_tdata[CHAR_W-1:0]});
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(square_type)-1:0];
            if (expected_squares.size() == 0)
               flag_error($sformatf("unexpected word: side %0d col %0d row %0d",
                                    got.side, got.right_col, got.bottom_row));
            else begin
               want = expected_squares.pop_front();
               if (got.side != want.side || got.right_col != want.right_col ||
                   got.bottom_row != want.bottom_row)
                  flag_error($sformatf({"square mismatch: expected side %0d col %0d row %0d,",
                                        " got side %0d col %0d row %0d"},
                                       want.side, want.right_col, want.bottom_row,
                                       got.side, got.right_col, got.bottom_row));
            end
         end
      end
   end

   // cell driver
   int req_gap = 0;
   bit req_burst = 1'b0;
   always @(negedge clock) begin
      map_cell_type mcell;
      if (reset)
         req_tvalid <= 1'b0;
      else if (req_tvalid && !req_took)
         ; // word still waiting for the block
      else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
         mcell = pending_cells.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= mcell.ch;
         req_tlast <= mcell.last;
         if ($urandom_range(0, 23) == 0) req_burst = !req_burst;
         req_gap = draw_gap(req_burst);
      end else
         req_tvalid <= 1'b0;
   end

   // result receiver, with one long hold-off while plenty of cells are still queued
   int  rsp_stall = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  rsp_burst = 1'b0;
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && pending_cells.size() > 60) begin
         hold_done = 1'b1;
         hold_left = 600;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 7) == 0) rsp_burst = !rsp_burst;
            rsp_stall = draw_gap(rsp_burst);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_map_format(int unsigned w, logic [CHAR_W-1:0] e, logic [CHAR_W-1:0] o);
      write_reg(CSR_ROW_WIDTH, w);
      write_reg(CSR_EMPTY_CHAR, e);
      write_reg(CSR_OBSTACLE_CHAR, o);
      cur_empty = e;
      cur_obst = o;
      @(posedge clock);
   endtask

   function automatic void push_cell(logic [CHAR_W-1:0] ch, logic last);
      pending_cells.push_back({last, ch});
      cells_queued++;
   endfunction

   // mostly empty cells so squares grow, a few obstacles and some random codes
   function automatic void add_map(int n, int empty_pct);
      for (int i = 0; i < n; i++) begin
         int r;
         logic [CHAR_W-1:0] ch;
         r = $urandom_range(0, 99);
         if (r < 5) ch = CHAR_W'($urandom_range(0, 255));
         else if (r < 5 + empty_pct) ch = cur_empty;
         else ch = cur_obst;
         push_cell(ch, i == n - 1);
      end
   endfunction

   // block is idle once every cell is taken and every word has come back
   task automatic drain();
      do @(negedge clock);
      while (cells_taken != cells_queued || expected_squares.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int w_eff, n, n_items;
      int unsigned w_reg;
      logic [CHAR_W-1:0] e, o;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: width 1, '.' empty, 'o' obstacle
      push_cell(ROCK, 1'b0);
      push_cell(DOT, 1'b1);
      drain();

      set_map_format(3, DOT, ROCK);
      for (int i = 0; i < 9; i++) push_cell(DOT, i == 8);        // full 3x3
      push_cell(ROCK, 1'b0);                                     // nothing empty
      push_cell(8'hFF, 1'b0);
      push_cell(8'h00, 1'b0);
      push_cell(ROCK, 1'b1);
      push_cell(DOT, 1'b1);                                      // one-cell map
      push_cell(DOT, 1'b0);                                      // tie in the first row
      push_cell(DOT, 1'b1);
      drain();

      // empty and obstacle codes equal: obstacle wins even on the border
      set_map_format(3, 8'h00, 8'h00);
      push_cell(8'h00, 1'b0);
      push_cell(8'h07, 1'b0);
      push_cell(8'h07, 1'b0);
      push_cell(8'h07, 1'b0);
      push_cell(8'h07, 1'b1);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin w_reg = 0; e = 8'hFF; o = 8'h00; end
            1: begin w_reg = 2; e = 8'h00; o = 8'hFF; end
            2: begin
               w_reg = 1;
               e = CHAR_W'($urandom_range(0, 255));
               o = CHAR_W'($urandom_range(0, 255));
            end
            default: begin
               w_reg = $urandom_range(1, 12);
               e = CHAR_W'($urandom_range(0, 255));
               o = CHAR_W'($urandom_range(0, 255));
            end
         endcase
         set_map_format(w_reg, e, o);
         w_eff = (w_reg == 0) ? 1 : w_reg;
         n_items = 0;
         while (n_items < 140) begin
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 3);
            else n = w_eff * $urandom_range(1, 5) + $urandom_range(0, w_eff - 1);
            add_map(n, $urandom_range(55, 95));
            n_items += n;
         end
         drain();
      end

      set_map_format(4, DOT, ROCK);
      add_map(4, 80);
      drain();

      err_count += expected_squares.size();
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
